/* src/fssrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssrt_pkg: shared types and constants
// Payload structs, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fssrt_pkg;

	// Widest cell address: four lines of eight machines
	localparam int CELL_ADDR_W = 5;
	// Results emitted per job at most
	localparam int RESULT_LIMIT = 16;

	typedef struct packed {
		logic [15:0] proc_time;
		logic [1:0]  line_index;
		logic [2:0]  machine_index;
		logic [3:0]  shared_machines;
		logic        first_job;
		logic        job_end;
	} in_item_t;

	typedef struct packed {
		logic [31:0] start_time;
		logic [1:0]  out_line;
		logic [2:0]  out_machine;
		logic        last_of_job;
		logic        saturated;
	} result_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_LINES_IN_USE    = 3'd0,
		CFG_MACHINES_LINE_0 = 3'd1,
		CFG_MACHINES_LINE_1 = 3'd2,
		CFG_MACHINES_LINE_2 = 3'd3,
		CFG_MACHINES_LINE_3 = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FWD,
		ST_RECON,
		ST_EMIT
	} ctrl_state_t;

	// Datapath step operations
	typedef enum logic [1:0] {
		OP_FWD,
		OP_JOIN,
		OP_RECON
	} step_op_t;

	typedef struct packed {
		logic                   job_start;
		logic                   use_prev;
		logic                   run_clear;
		logic                   ct_we;
		logic                   step;
		step_op_t               op;
		logic                   emit;
		logic [CELL_ADDR_W-1:0] addr;
		logic [1:0]             line;
		logic [2:0]             machine;
		logic                   last;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

/* src/fssrt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssrt_if: channel interfaces
// Valid/ready channels for job items, start-time results and register writes.
// ----------------------------------------------------------------------------
interface fssrt_item_if
	import fssrt_pkg::*;
;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fssrt_result_if
	import fssrt_pkg::*;
;
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fssrt_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [3:0] value;

	modport source (output valid, output index, output value, input ready);
	modport sink (input valid, input index, input value, output ready);
endinterface

/* src/flow_shop_reconciled_start_times.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_shop_reconciled_start_times: flow-shop start times with reconciliation
// Top level joining the sequencing controller and the start-time datapath.
// ----------------------------------------------------------------------------
// A job arrives as a run of processing-time requests on the times channel, one
// per line and machine, and one request is taken every cycle while idle. The
// request with job_end set starts the computation: the block then accepts
// nothing while a single saturating add-and-max unit walks every line up to
// its reconciliation machine, joins the lines into one common start, and
// walks the remaining machines. After that it emits one start time per cycle,
// at most 16 per job, line by line and machine by machine; a stalled starts
// channel holds the walk. Input requests are taken again once the last result
// is in the output register. Register writes on cfg are taken in any cycle and
// must only be issued while idle.
// ----------------------------------------------------------------------------
module flow_shop_reconciled_start_times
	import fssrt_pkg::*;
#(
	parameter int MAX_LINES    = 2,
	parameter int MAX_MACHINES = 8,
	parameter int TIME_WIDTH   = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	fssrt_item_if.sink          times,
	fssrt_result_if.source      starts,
	fssrt_cfg_if.sink           cfg
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;
	logic     out_valid;
	result_t  out_item;

	// register writes never stall
	assign cfg.ready = 1'b1;

	// sequence the job: load, walk lines, join, emit
	fssrt_ctrl #(
		.MAX_LINES    (MAX_LINES),
		.MAX_MACHINES (MAX_MACHINES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (times.valid),
		.in_item   (times.data),
		.in_ready  (in_ready),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_value (cfg.value),
		.cmd       (cmd),
		.stat      (stat)
	);

	// hold times and finishes, compute starts, drive the output register
	fssrt_dp #(
		.MAX_LINES    (MAX_LINES),
		.MAX_MACHINES (MAX_MACHINES),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.proc_time (times.data.proc_time),
		.stat      (stat),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_ready (starts.ready)
	);

	assign times.ready  = in_ready;
	assign starts.valid = out_valid;
	assign starts.data  = out_item;

endmodule

/* src/fssrt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssrt_ctrl: sequencing controller
// Holds configuration, walks lines and machines for one job and issues
// datapath steps and result emits.
// ----------------------------------------------------------------------------
module fssrt_ctrl
	import fssrt_pkg::*;
#(
	parameter int MAX_LINES    = 2,
	parameter int MAX_MACHINES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  in_item_t   in_item,
	output logic       in_ready,
	input  logic       cfg_valid,
	input  logic [2:0] cfg_index,
	input  logic [3:0] cfg_value,
	output dp_cmd_t    cmd,
	input  dp_stat_t   stat
);

	ctrl_state_t state_q, state_d;
	logic [1:0]  line_q, line_d;
	logic [2:0]  mach_q, mach_d;
	logic [4:0]  n_q, n_d;
	logic [3:0]  sh_q, sh_d;
	logic        have_prev_q, have_prev_d;
	logic [2:0]  lines_q;
	logic [3:0]  mach_cfg_q [4];

	logic [2:0] nl;
	logic [3:0] m_cur;
	logic [3:0] m_in;
	logic [2:0] rec_cur;
	logic [2:0] rec_next;
	logic [2:0] rec_first;
	logic [1:0] line_nx;
	logic       last_line;
	logic       m_last;
	logic       in_range;

	function automatic logic [3:0] eff_m(input logic [3:0] raw);
		if (raw == 4'd0) return 4'd1;
		if (raw > 4'(MAX_MACHINES)) return 4'(MAX_MACHINES);
		return raw;
	endfunction

	function automatic logic [2:0] rec_of(input logic [3:0] m, input logic [3:0] sh);
		logic [3:0] s;
		s = sh;
		if (s == 4'd0) s = 4'd1;
		if (s > m) s = m;
		return 3'(m - s);
	endfunction

	function automatic logic [CELL_ADDR_W-1:0] cell_of(input logic [1:0] l,
		input logic [2:0] k);
		logic [5:0] c;
		c = 6'(l) * 6'(MAX_MACHINES) + 6'(k);
		return c[CELL_ADDR_W-1:0];
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= 3'd2;
			for (int i = 0; i < 4; i++) mach_cfg_q[i] <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LINES_IN_USE:    lines_q       <= cfg_value[2:0];
				CFG_MACHINES_LINE_0: mach_cfg_q[0] <= cfg_value;
				CFG_MACHINES_LINE_1: mach_cfg_q[1] <= cfg_value;
				CFG_MACHINES_LINE_2: mach_cfg_q[2] <= cfg_value;
				CFG_MACHINES_LINE_3: mach_cfg_q[3] <= cfg_value;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (lines_q == 3'd0) nl = 3'd1;
		else if (lines_q > 3'(MAX_LINES)) nl = 3'(MAX_LINES);
		else nl = lines_q;
	end

	assign line_nx   = 2'(line_q + 2'd1);
	assign m_cur     = eff_m(mach_cfg_q[line_q]);
	assign m_in      = eff_m(mach_cfg_q[in_item.line_index]);
	assign rec_cur   = rec_of(m_cur, sh_q);
	assign rec_next  = rec_of(eff_m(mach_cfg_q[line_nx]), sh_q);
	assign rec_first = rec_of(eff_m(mach_cfg_q[0]), sh_q);
	assign last_line = ({1'b0, line_q} + 3'd1) == nl;
	assign m_last    = ({1'b0, mach_q} + 4'd1) == m_cur;
	assign in_range  = ({1'b0, in_item.line_index} < nl)
		&& ({1'b0, in_item.machine_index} < m_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			line_q      <= 2'd0;
			mach_q      <= 3'd0;
			n_q         <= 5'd0;
			sh_q        <= 4'd1;
			have_prev_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			line_q      <= line_d;
			mach_q      <= mach_d;
			n_q         <= n_d;
			sh_q        <= sh_d;
			have_prev_q <= have_prev_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		line_d      = line_q;
		mach_d      = mach_q;
		n_d         = n_q;
		sh_d        = sh_q;
		have_prev_d = have_prev_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.op      = OP_FWD;
		cmd.addr    = cell_of(line_q, mach_q);
		cmd.line    = line_q;
		cmd.machine = mach_q;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.addr = cell_of(in_item.line_index, in_item.machine_index);
				if (in_valid) begin
					cmd.ct_we = in_range;
					if (in_item.job_end) begin
						cmd.job_start = 1'b1;
						cmd.use_prev  = have_prev_q && !in_item.first_job;
						have_prev_d   = 1'b1;
						sh_d          = in_item.shared_machines;
						line_d        = 2'd0;
						mach_d        = 3'd0;
						state_d       = ST_FWD;
					end
				end
			end
			// walk each line up to its reconciliation machine
			ST_FWD: begin
				cmd.step = 1'b1;
				if (mach_q < rec_cur) begin
					cmd.op = OP_FWD;
					mach_d = 3'(mach_q + 3'd1);
				end else begin
					cmd.op = OP_JOIN;
					if (last_line) begin
						line_d  = 2'd0;
						mach_d  = rec_first;
						state_d = ST_RECON;
					end else begin
						cmd.run_clear = 1'b1;
						line_d        = line_nx;
						mach_d        = 3'd0;
					end
				end
			end
			// common start, then the rest of each line
			ST_RECON: begin
				cmd.step = 1'b1;
				cmd.op   = (mach_q == rec_cur) ? OP_RECON : OP_FWD;
				if (m_last) begin
					if (last_line) begin
						line_d  = 2'd0;
						mach_d  = 3'd0;
						n_d     = 5'd0;
						state_d = ST_EMIT;
					end else begin
						line_d = line_nx;
						mach_d = rec_next;
					end
				end else begin
					mach_d = 3'(mach_q + 3'd1);
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = (n_q == 5'(RESULT_LIMIT - 1)) || (last_line && m_last);
					n_d      = 5'(n_q + 5'd1);
					if (cmd.last) begin
						state_d = ST_IDLE;
					end else if (m_last) begin
						line_d = line_nx;
						mach_d = 3'd0;
					end else begin
						mach_d = 3'(mach_q + 3'd1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/fssrt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssrt_dp: start-time datapath
// Time and finish stores, one saturating add with max per step, start-time
// store and the result output register.
// ----------------------------------------------------------------------------
module fssrt_dp
	import fssrt_pkg::*;
#(
	parameter int MAX_LINES    = 2,
	parameter int MAX_MACHINES = 8,
	parameter int TIME_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [15:0] proc_time,
	output dp_stat_t    stat,
	output logic        out_valid,
	output result_t     out_item,
	input  logic        out_ready
);

	localparam int CELLS  = MAX_LINES * MAX_MACHINES;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic [15:0]           ct_q [CELLS];
	logic [TIME_WIDTH-1:0] pf_q [CELLS];
	logic [TIME_WIDTH-1:0] r_q  [CELLS];
	logic [TIME_WIDTH-1:0] run_q;
	logic [TIME_WIDTH-1:0] jr_q;
	logic                  sat_q;
	logic                  use_prev_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic [CELL_W-1:0]     idx;
	logic [TIME_WIDTH-1:0] f;
	logic [TIME_WIDTH-1:0] p;
	logic [TIME_WIDTH-1:0] join_v;
	logic [TIME_WIDTH-1:0] tmp;
	logic [TIME_WIDTH:0]   sum_w;
	logic                  carry;
	logic [TIME_WIDTH-1:0] fin;
	logic                  wr_cell;

	assign idx     = cmd.addr[CELL_W-1:0];
	assign f       = use_prev_q ? pf_q[idx] : '0;
	assign p       = TIME_WIDTH'(ct_q[idx]);
	assign join_v  = (run_q > f) ? run_q : f;
	assign tmp     = (cmd.op == OP_RECON) ? jr_q : join_v;
	assign sum_w   = {1'b0, tmp} + {1'b0, p};
	assign carry   = sum_w[TIME_WIDTH];
	assign fin     = carry ? '1 : sum_w[TIME_WIDTH-1:0];
	assign wr_cell = cmd.step && (cmd.op != OP_JOIN);

	always_ff @(posedge clk) begin
		if (cmd.ct_we) ct_q[idx] <= proc_time;
		if (wr_cell) r_q[idx] <= tmp;
	end

	// finish times of the previous job, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) pf_q[i] <= '0;
		end else if (wr_cell) begin
			pf_q[idx] <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.job_start) begin
			run_q      <= '0;
			jr_q       <= '0;
			sat_q      <= 1'b0;
			use_prev_q <= cmd.use_prev;
		end else if (cmd.run_clear) begin
			run_q <= '0;
			if (join_v > jr_q) jr_q <= join_v;
		end else if (cmd.step) begin
			if (cmd.op == OP_JOIN) begin
				if (join_v > jr_q) jr_q <= join_v;
			end else begin
				run_q <= fin;
				if (carry) sat_q <= 1'b1;
			end
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.start_time  <= 32'(r_q[idx]);
			out_q.out_line    <= cmd.line;
			out_q.out_machine <= cmd.machine;
			out_q.last_of_job <= cmd.last;
			out_q.saturated   <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* test/fssrt_start_board_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fssrt_start_board_pkg: start-time predictor and result checker
// Keeps its own copy of the job times, the previous job's finish times and
// the line setup, and predicts every start time that a job end produces.
// ----------------------------------------------------------------------------
package fssrt_start_board_pkg;
	import fssrt_pkg::*;

	// Sizes of the block as instantiated (default parameters)
	localparam int SHOP_LINES    = 2;
	localparam int SHOP_MACHINES = 8;
	localparam int SHOP_CELLS    = SHOP_LINES * SHOP_MACHINES;

	class start_time_board;
		bit [2:0]  lines_reg;
		bit [3:0]  machines_reg [4];
		bit [15:0] job_times [SHOP_CELLS];
		bit [31:0] prev_finish [SHOP_CELLS];
		bit        have_prev;
		bit        sat_seen;
		result_t   pending_starts [$];
		int        errors;
		int        items_taken;
		int        jobs_done;
		int        starts_checked;
		int        saturated_jobs;

		function new();
			lines_reg = 3'd2;
			foreach (machines_reg[i]) machines_reg[i] = 4'd8;
			foreach (job_times[i]) job_times[i] = '0;
			foreach (prev_finish[i]) prev_finish[i] = '0;
			have_prev = 1'b0;
			errors = 0;
			items_taken = 0;
			jobs_done = 0;
			starts_checked = 0;
			saturated_jobs = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, bit [3:0] value);
			case (idx)
				CFG_LINES_IN_USE:    lines_reg = value[2:0];
				CFG_MACHINES_LINE_0: machines_reg[0] = value;
				CFG_MACHINES_LINE_1: machines_reg[1] = value;
				CFG_MACHINES_LINE_2: machines_reg[2] = value;
				CFG_MACHINES_LINE_3: machines_reg[3] = value;
				default: ;
			endcase
		endfunction

		function int eff_lines();
			int n;
			n = lines_reg;
			if (n < 1) n = 1;
			if (n > SHOP_LINES) n = SHOP_LINES;
			return n;
		endfunction

		function int eff_machines(int line);
			int n;
			n = machines_reg[line & 3];
			if (n < 1) n = 1;
			if (n > SHOP_MACHINES) n = SHOP_MACHINES;
			return n;
		endfunction

		// Saturating add; note any overflow for the job's flag
		function bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
			bit [32:0] sum;
			sum = {1'b0, a} + {1'b0, b};
			if (sum[32]) begin
				sat_seen = 1'b1;
				return '1;
			end
			return sum[31:0];
		endfunction

		function bit [31:0] max32(bit [31:0] a, bit [31:0] b);
			return (a > b) ? a : b;
		endfunction

		// Note one accepted time request; on a job end queue the job's starts
		function void take_times(in_item_t it);
			int        nl, li, mi, m, s, n, b;
			int        rec [SHOP_LINES];
			bit [31:0] pf [SHOP_CELLS];
			bit [31:0] st [SHOP_CELLS];
			bit [31:0] joint;
			result_t   r;
			items_taken++;
			nl = eff_lines();
			li = it.line_index;
			mi = it.machine_index;
			if (li < nl && mi < eff_machines(li))
				job_times[li * SHOP_MACHINES + mi] = it.proc_time;
			if (!it.job_end)
				return;

			sat_seen = 1'b0;
			joint = '0;
			for (int c = 0; c < SHOP_CELLS; c++) begin
				pf[c] = (it.first_job || !have_prev) ? 32'd0 : prev_finish[c];
				st[c] = '0;
			end
			// walk every line up to its reconciliation machine
			for (int sl = 0; sl < nl; sl++) begin
				b = sl * SHOP_MACHINES;
				m = eff_machines(sl);
				s = it.shared_machines;
				if (s < 1) s = 1;
				if (s > m) s = m;
				rec[sl] = m - s;
				st[b] = pf[b];
				for (int k = 1; k < rec[sl]; k++)
					st[b + k] = max32(sat_add(st[b + k - 1], job_times[b + k - 1]), pf[b + k]);
				if (rec[sl] >= 1)
					joint = max32(joint,
						sat_add(st[b + rec[sl] - 1], job_times[b + rec[sl] - 1]));
			end
			for (int sl = 0; sl < nl; sl++)
				joint = max32(joint, pf[sl * SHOP_MACHINES + rec[sl]]);
			// common start at the join, then the plain recurrence again
			for (int sl = 0; sl < nl; sl++) begin
				b = sl * SHOP_MACHINES;
				m = eff_machines(sl);
				st[b + rec[sl]] = joint;
				for (int k = rec[sl] + 1; k < m; k++)
					st[b + k] = max32(sat_add(st[b + k - 1], job_times[b + k - 1]), pf[b + k]);
			end
			for (int sl = 0; sl < nl; sl++) begin
				b = sl * SHOP_MACHINES;
				m = eff_machines(sl);
				for (int k = 0; k < m; k++)
					prev_finish[b + k] = sat_add(st[b + k], job_times[b + k]);
			end
			have_prev = 1'b1;
			jobs_done++;
			if (sat_seen) saturated_jobs++;

			n = 0;
			for (int sl = 0; sl < nl; sl++) begin
				m = eff_machines(sl);
				for (int k = 0; k < m && n < RESULT_LIMIT; k++) begin
					r.start_time = st[sl * SHOP_MACHINES + k];
					r.out_line = sl[1:0];
					r.out_machine = k[2:0];
					r.last_of_job = 1'b0;
					r.saturated = sat_seen;
					pending_starts.push_back(r);
					n++;
				end
			end
			pending_starts[pending_starts.size() - 1].last_of_job = 1'b1;
		endfunction

		function void field_diff(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		endfunction

		// Compare one accepted start time with the oldest prediction
		function void check_start(result_t got);
			result_t want;
			if (pending_starts.size() == 0) begin
				errors++;
				$display("%0t: start time with none expected, expected nothing, actual %0h",
					$time, got);
				return;
			end
			want = pending_starts.pop_front();
			starts_checked++;
			if (got !== want) begin
				errors++;
				field_diff("start_time", want.start_time, got.start_time);
				field_diff("out_line", want.out_line, got.out_line);
				field_diff("out_machine", want.out_machine, got.out_machine);
				field_diff("last_of_job", want.last_of_job, got.last_of_job);
				field_diff("saturated", want.saturated, got.saturated);
			end
		endfunction
	endclass

endpackage

/* test/tb_flow_shop_reconciled_start_times.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_shop_reconciled_start_times: self-checking bench for the block
// Feeds jobs of processing times under a series of line setups, with random
// gaps and stalls on both channels, and checks every start time in order
// against a cycle-free predictor of the flow-shop recurrence.
// ----------------------------------------------------------------------------
module tb_flow_shop_reconciled_start_times;
	import fssrt_pkg::*;
	import fssrt_start_board_pkg::*;

	localparam int CYCLE_LIMIT     = 1_500_000;
	localparam int RANDOM_ITEMS    = 470;
	// leave room after drain
	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_OFF_CYCLES = 300;

	logic clk;
	logic arst_n;

	fssrt_item_if   times_ch ();
	fssrt_result_if starts_ch ();
	fssrt_cfg_if    cfg_ch ();

	flow_shop_reconciled_start_times DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.times  (times_ch),
		.starts (starts_ch),
		.cfg    (cfg_ch)
	);

	start_time_board board;
	int              cycle_count;
	int              hold_request;   // receiver picks this up and holds off
	bit              feed_gaps;      // sender may idle between requests
	int              counted_items;  // requests that store a time or end a job
	int              setups_done;
	int              hold_offs;
	bit              cell_loaded [SHOP_CELLS];  // time written since reset

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// Processing time: favor the extremes and small values
	function automatic logic [15:0] pick_time();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3, 4, 5: return 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Machine count: mostly legal, sometimes anything the register holds
	function automatic logic [3:0] pick_count();
		if ($urandom_range(0, 9) < 7)
			return 4'($urandom_range(1, 8));
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic in_item_t make_item(int line, int mach, bit ends_job);
		in_item_t it;
		it.proc_time = pick_time();
		it.line_index = line[1:0];
		it.machine_index = mach[2:0];
		it.shared_machines = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(1, 8));
		it.first_job = ($urandom_range(0, 9) == 0);
		it.job_end = ends_job;
		return it;
	endfunction

	// Offer one time request and hold it until the block takes it
	task automatic offer_item(input in_item_t it);
		int li;
		int mi;
		bit in_area;
		times_ch.valid <= 1'b1;
		times_ch.data <= it;
		do @(posedge clk); while (!times_ch.ready);
		li = it.line_index;
		mi = it.machine_index;
		in_area = li < board.eff_lines() && mi < board.eff_machines(li);
		if (in_area) cell_loaded[li * SHOP_MACHINES + mi] = 1'b1;
		if (in_area || it.job_end) counted_items++;
		board.take_times(it);
		// drop valid only when a gap follows; otherwise the next request keeps it high
		if (feed_gaps && $urandom_range(0, 99) < 30) begin
			times_ch.valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	// Stop feeding and wait until every predicted start time is back
	task automatic drain_starts();
		times_ch.valid <= 1'b0;
		while (board.pending_starts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [3:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.value <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		board.set_reg(idx, value);
	endtask

	// Load a full line setup; only ever done with the block idle
	task automatic apply_setup(input logic [3:0] lines, input logic [3:0] m0,
		input logic [3:0] m1, input logic [3:0] m2, input logic [3:0] m3);
		drain_starts();
		write_reg(CFG_LINES_IN_USE, lines);
		write_reg(CFG_MACHINES_LINE_0, m0);
		write_reg(CFG_MACHINES_LINE_1, m1);
		write_reg(CFG_MACHINES_LINE_2, m2);
		write_reg(CFG_MACHINES_LINE_3, m3);
		cfg_ch.valid <= 1'b0;
		setups_done++;
	endtask

	// One job. A well-formed job loads every cell once in random order and ends
	// on the last one. A broken job reloads only some cells, mixes in stray
	// requests (often outside the lines in use) and ends anywhere. Cells never
	// loaded since reset are always loaded before the end so no stale read occurs.
	task automatic send_job(input bit broken);
		int nl;
		int cell_order [$];
		int pick;
		int tmp;
		int c;
		int el;
		nl = board.eff_lines();
		for (int l = 0; l < nl; l++)
			for (int k = 0; k < board.eff_machines(l); k++) begin
				c = l * SHOP_MACHINES + k;
				if (!broken || !cell_loaded[c] || $urandom_range(0, 1) == 1)
					cell_order.push_back(c);
			end
		for (int i = cell_order.size() - 1; i > 0; i--) begin
			pick = $urandom_range(0, i);
			tmp = cell_order[i];
			cell_order[i] = cell_order[pick];
			cell_order[pick] = tmp;
		end
		if (!broken) begin
			foreach (cell_order[i])
				offer_item(make_item(cell_order[i] / SHOP_MACHINES,
					cell_order[i] % SHOP_MACHINES, i == cell_order.size() - 1));
		end else begin
			foreach (cell_order[i]) begin
				if ($urandom_range(0, 3) == 0)
					offer_item(make_item($urandom_range(0, 3), $urandom_range(0, 7), 1'b0));
				offer_item(make_item(cell_order[i] / SHOP_MACHINES,
					cell_order[i] % SHOP_MACHINES, 1'b0));
			end
			if ($urandom_range(0, 1) == 1) begin
				el = $urandom_range(0, nl - 1);
				offer_item(make_item(el, $urandom_range(0, board.eff_machines(el) - 1), 1'b1));
			end else begin
				offer_item(make_item($urandom_range(0, 3), $urandom_range(0, 7), 1'b1));
			end
		end
	endtask

	// Receiver: alternate steady and choppy stretches, honor long hold-offs
	initial begin
		int  stall_left;
		int  hold_left;
		int  stretch;
		bit  choppy;
		stall_left = 0;
		hold_left = 0;
		stretch = 0;
		choppy = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (stretch == 0) begin
				choppy = $urandom_range(0, 2) != 0;
				stretch = $urandom_range(50, 200);
			end
			stretch--;
			if (!arst_n) begin
				starts_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				starts_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				starts_ch.ready <= 1'b0;
			end else if (choppy && $urandom_range(0, 99) < 30) begin
				stall_left = pick_gap() - 1;
				starts_ch.ready <= 1'b0;
			end else begin
				starts_ch.ready <= 1'b1;
			end
		end
	end

	// Check every start time that the receiver takes
	always @(posedge clk) begin
		if (arst_n && starts_ch.valid && starts_ch.ready)
			board.check_start(starts_ch.data);
	end

	// Watchdog: end a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d start times still expected",
			cycle_count, board.pending_starts.size());
		$display("[flow_shop_reconciled_start_times] ERROR");
		$finish;
	end

	initial begin
		int phase;
		int jobs;
		board = new();
		arst_n <= 1'b0;
		times_ch.valid <= 1'b0;
		times_ch.data <= '0;
		starts_ch.ready <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_LINES_IN_USE;
		cfg_ch.value <= '0;
		feed_gaps = 1'b0;
		hold_request = 0;
		counted_items = 0;
		setups_done = 0;
		hold_offs = 0;
		foreach (cell_loaded[i]) cell_loaded[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero line and machine counts clamp up to one; shared count
		// of zero clamps to one; a first job at full time; a stray request on a
		// line not in use; a job end outside the lines in use still triggers
		// and picks up the previous finish.
		apply_setup(4'd0, 4'd0, 4'd8, 4'd8, 4'd8);
		offer_item(in_item_t'{16'hFFFF, 2'd0, 3'd0, 4'd0, 1'b1, 1'b1});
		offer_item(in_item_t'{16'h0000, 2'd3, 3'd7, 4'd15, 1'b0, 1'b0});
		offer_item(in_item_t'{16'h007B, 2'd1, 3'd0, 4'd15, 1'b0, 1'b1});

		// Line count above the limit clamps to two; line one has one machine.
		// Shared count one puts the join at the last machine; shared count
		// beyond the line length puts it at machine zero (no own finish term);
		// then a new sequence with zero times drops the previous finishes.
		apply_setup(4'd7, 4'd2, 4'd1, 4'd15, 4'd15);
		offer_item(in_item_t'{16'hFFFF, 2'd0, 3'd0, 4'd1, 1'b0, 1'b0});
		offer_item(in_item_t'{16'hFFFF, 2'd0, 3'd1, 4'd1, 1'b0, 1'b0});
		offer_item(in_item_t'{16'hFFFF, 2'd1, 3'd0, 4'd1, 1'b0, 1'b1});
		offer_item(in_item_t'{16'h0001, 2'd0, 3'd0, 4'd8, 1'b0, 1'b0});
		offer_item(in_item_t'{16'hFFFE, 2'd0, 3'd1, 4'd8, 1'b0, 1'b0});
		offer_item(in_item_t'{16'h8000, 2'd1, 3'd0, 4'd8, 1'b0, 1'b1});
		offer_item(in_item_t'{16'h0000, 2'd1, 3'd0, 4'd2, 1'b0, 1'b0});
		offer_item(in_item_t'{16'h0000, 2'd0, 3'd1, 4'd2, 1'b0, 1'b0});
		offer_item(in_item_t'{16'h0000, 2'd0, 3'd0, 4'd2, 1'b1, 1'b1});

		// Random phases: extreme setups first, then random ones
		counted_items = 0;
		phase = 0;
		while (counted_items < RANDOM_ITEMS) begin
			case (phase)
				0: apply_setup(4'd1, 4'd1, 4'd1, 4'd1, 4'd1);
				1: apply_setup(4'd2, 4'd8, 4'd8, 4'd8, 4'd8);
				2: apply_setup(4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
				3: apply_setup(4'd7, 4'd15, 4'd15, 4'd15, 4'd15);
				default: apply_setup(4'($urandom_range(0, 7)), pick_count(), pick_count(),
					pick_count(), pick_count());
			endcase
			// hold the receiver off so the block fills and stalls its input
			if (phase == 1 || phase == 7) begin
				hold_request = HOLD_OFF_CYCLES;
				hold_offs++;
			end
			jobs = $urandom_range(3, 8);
			repeat (jobs) begin
				// stop once the request budget is spent
				if (counted_items < RANDOM_ITEMS) begin
					feed_gaps = $urandom_range(0, 3) != 0;
					send_job($urandom_range(0, 3) == 0);
				end
			end
			phase++;
		end
		drain_starts();

		$display("covered %0d time requests, %0d jobs, %0d start times under %0d setups",
			board.items_taken, board.jobs_done, board.starts_checked, setups_done);
		$display("receiver held off %0d times for %0d cycles; %0d mismatches",
			hold_offs, HOLD_OFF_CYCLES, board.errors);
		if (board.errors == 0)
			$display("[flow_shop_reconciled_start_times] OK");
		else
			$display("[flow_shop_reconciled_start_times] ERROR");
		$finish;
	end

endmodule

/* files.f */
src/fssrt_pkg.sv
src/fssrt_if.sv
src/fssrt_ctrl.sv
src/fssrt_dp.sv
src/flow_shop_reconciled_start_times.sv
test/fssrt_start_board_pkg.sv
test/tb_flow_shop_reconciled_start_times.sv
